// ===== rtl/pmm_pkg.sv =====
// ---------------------------------------------------------------------------
// pmm_pkg
// shared types, constants and modulus tables for the pseudo-Mersenne
// modular multiplier
// ---------------------------------------------------------------------------
package pmm_pkg;

  localparam int OPW        = 63;
  localparam int PIPE_DEPTH = 10;

  localparam logic [1:0] SEL_P0 = 2'd0;
  localparam logic [1:0] SEL_P1 = 2'd1;
  localparam logic [1:0] SEL_P2 = 2'd2;

  localparam logic [1:0] MODSEL_RST = SEL_P1;

  localparam logic REG_MODSEL = 1'b0;

  localparam logic [OPW-1:0] OPERAND_BOUND = 63'd4611686018428010497;

  localparam logic [OPW-1:0] PRIME0 = 63'd1152921504606904321;
  localparam logic [OPW-1:0] PRIME1 = 63'd4611686018427494401;
  localparam logic [OPW-1:0] PRIME2 = 63'd4611686018428010497;

  localparam logic [19:0] CONST0 = 20'd57345;
  localparam logic [19:0] CONST1 = 20'd106497;
  localparam logic [19:0] CONST2 = 20'd622593;

  typedef struct packed {
    logic [OPW-1:0] operand_a;
    logic [OPW-1:0] operand_b;
  } pmm_in_t;

  typedef struct packed {
    logic [OPW-1:0] residue;
    logic           range_error;
  } pmm_out_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] sel;
    logic       err;
  } pmm_ctl_t;

  function automatic logic [19:0] sel_c(input logic [1:0] sel);
    logic [19:0] c;
    unique case (sel)
      SEL_P0:  c = CONST0;
      SEL_P1:  c = CONST1;
      default: c = CONST2;
    endcase
    return c;
  endfunction

  function automatic logic [OPW-1:0] sel_p(input logic [1:0] sel);
    logic [OPW-1:0] p;
    unique case (sel)
      SEL_P0:  p = PRIME0;
      SEL_P1:  p = PRIME1;
      default: p = PRIME2;
    endcase
    return p;
  endfunction

  // k = 60 for the small prime, 62 otherwise
  function automatic logic sel_k60(input logic [1:0] sel);
    return sel == SEL_P0;
  endfunction

endpackage

// ===== rtl/pseudo_mersenne_modmul.sv =====
// ---------------------------------------------------------------------------
// pseudo_mersenne_modmul
// modular multiply by one of three pseudo-Mersenne primes, fully pipelined
//
// requests: pulse start with in_req (operand_a, operand_b); busy stays low,
// so a request is taken in every cycle in which start is high
// results: out_res is shown for one cycle with out_strobe high, after the
// ten register stages, in request order
// throughput: one request per cycle; the 63x63 multiply and the two folds
// are spread over ten register stages
// range: an operand at or above 2^62+622593 is cut to its low 62 bits
// and range_error is set on its result
// config: APB register 0 (modulus_select) picks the prime, reset value 1;
// write it only while no request is in flight
// reset: synchronous, clears the stage valid bits; requests in flight
// are dropped
// the receiver cannot stall, so there is no backpressure path
// ---------------------------------------------------------------------------
module pseudo_mersenne_modmul import pmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pmm_in_t     in_req,
  output logic        out_strobe,
  output pmm_out_t    out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]   modsel_r, modsel_nxt;
  logic         cfg_wr;
  pmm_ctl_t     in_ctl;
  pmm_ctl_t     mul_ctl, fold_ctl;
  logic [125:0] prod;
  logic [82:0]  y;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_MODSEL);
  assign modsel_nxt = cfg_wr ? pwdata[1:0] : modsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modsel_r <= MODSEL_RST;
    end else begin
      modsel_r <= modsel_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_MODSEL) ? {30'b0, modsel_r} : 32'b0;

  assign in_ctl = '{vld: start && !busy, sel: modsel_r, err: 1'b0};

  pmm_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (in_ctl),
    .in_req   (in_req),
    .out_ctl  (mul_ctl),
    .out_prod (prod)
  );

  pmm_fold1 u_fold1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (mul_ctl),
    .in_prod (prod),
    .out_ctl (fold_ctl),
    .out_y   (y)
  );

  pmm_fold2 u_fold2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (fold_ctl),
    .in_y    (y),
    .out_vld (out_strobe),
    .out_res (out_res)
  );

`ifndef SYNTH
  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_strobe)
    else $error("request did not produce a result after the pipeline depth");

  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.residue < PRIME2))
    else $error("residue not reduced below the largest prime");

  a_err_from_range: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.operand_a >= OPERAND_BOUND)) |->
      ##PIPE_DEPTH out_res.range_error)
    else $error("out-of-range operand not flagged");
`endif

endmodule

// ===== rtl/pmm_mult.sv =====
// ---------------------------------------------------------------------------
// pmm_mult
// operand range check and 63x63 multiply, split into four partial products
// of 32-bit and 31-bit operand halves and summed over two further stages
// ---------------------------------------------------------------------------
module pmm_mult import pmm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  pmm_ctl_t         in_ctl,
  input  pmm_in_t          in_req,
  output pmm_ctl_t         out_ctl,
  output logic [125:0]     out_prod
);

  pmm_ctl_t       ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r;
  pmm_ctl_t       ctl_a_nxt;
  logic [OPW-1:0] a_r, b_r, a_nxt, b_nxt;
  logic           a_oor, b_oor;

  logic [63:0]    p00_r, p00_nxt;
  logic [62:0]    p01_r, p01_nxt;
  logic [62:0]    p10_r, p10_nxt;
  logic [61:0]    p11_r, p11_nxt;

  logic [63:0]    mid_r, mid_nxt;
  logic [63:0]    q00_r;
  logic [61:0]    q11_r;

  logic [125:0]   prod_r, prod_nxt;

  // range check, out-of-range operands keep their low 62 bits
  assign a_oor = in_req.operand_a >= OPERAND_BOUND;
  assign b_oor = in_req.operand_b >= OPERAND_BOUND;
  assign a_nxt = a_oor ? {1'b0, in_req.operand_a[61:0]} : in_req.operand_a;
  assign b_nxt = b_oor ? {1'b0, in_req.operand_b[61:0]} : in_req.operand_b;

  always_comb begin
    ctl_a_nxt     = in_ctl;
    ctl_a_nxt.err = a_oor | b_oor;
  end

  // partial products
  assign p00_nxt = 64'(a_r[31:0])  * 64'(b_r[31:0]);
  assign p01_nxt = 63'(a_r[31:0])  * 63'(b_r[62:32]);
  assign p10_nxt = 63'(a_r[62:32]) * 63'(b_r[31:0]);
  assign p11_nxt = 62'(a_r[62:32]) * 62'(b_r[62:32]);

  assign mid_nxt  = 64'(p01_r) + 64'(p10_r);
  assign prod_nxt = {q11_r, q00_r} + 126'({mid_r, 32'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    p00_r  <= p00_nxt;
    p01_r  <= p01_nxt;
    p10_r  <= p10_nxt;
    p11_r  <= p11_nxt;
    mid_r  <= mid_nxt;
    q00_r  <= p00_r;
    q11_r  <= p11_r;
    prod_r <= prod_nxt;
  end

  assign out_ctl  = ctl_d_r;
  assign out_prod = prod_r;

endmodule

// ===== rtl/pmm_fold1.sv =====
// ---------------------------------------------------------------------------
// pmm_fold1
// first fold: y = (p << 20) + (prod mod 2^k) - c * (prod >> k)
// ---------------------------------------------------------------------------
module pmm_fold1 import pmm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pmm_ctl_t     in_ctl,
  input  logic [125:0] in_prod,
  output pmm_ctl_t     out_ctl,
  output logic [82:0]  out_y
);

  pmm_ctl_t     ctl_e_r, ctl_f_r, ctl_g_r;
  logic         k60;
  logic [19:0]  c;
  logic [65:0]  h;
  logic [61:0]  l;

  logic [52:0]  chl_r, chl_nxt;
  logic [52:0]  chh_r, chh_nxt;
  logic [61:0]  l_e_r, l_f_r;
  logic [83:0]  ch_r, ch_nxt;
  logic [83:0]  y_full;
  logic [82:0]  y_r;

  assign k60 = sel_k60(in_ctl.sel);
  assign c   = sel_c(in_ctl.sel);
  assign h   = k60 ? in_prod[125:60] : {2'b0, in_prod[125:62]};
  assign l   = k60 ? {2'b0, in_prod[59:0]} : in_prod[61:0];

  // high part times c, split in two 33-bit halves
  assign chl_nxt = 53'(h[32:0])  * 53'(c);
  assign chh_nxt = 53'(h[65:33]) * 53'(c);

  assign ch_nxt = 84'({chh_r, 33'b0}) + 84'(chl_r);

  // bias keeps y non-negative
  assign y_full = 84'({sel_p(ctl_f_r.sel), 20'b0}) + 84'(l_f_r) - ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r <= '0;
      ctl_f_r <= '0;
      ctl_g_r <= '0;
    end else begin
      ctl_e_r <= in_ctl;
      ctl_f_r <= ctl_e_r;
      ctl_g_r <= ctl_f_r;
    end
  end

  always_ff @(posedge clk) begin
    chl_r <= chl_nxt;
    chh_r <= chh_nxt;
    l_e_r <= l;
    ch_r  <= ch_nxt;
    l_f_r <= l_e_r;
    y_r   <= y_full[82:0];
  end

  assign out_ctl = ctl_g_r;
  assign out_y   = y_r;

endmodule

// ===== rtl/pmm_fold2.sv =====
// ---------------------------------------------------------------------------
// pmm_fold2
// second fold: z = (y mod 2^k) - c * (y >> k), plus p once if negative;
// drives the registered result
// ---------------------------------------------------------------------------
module pmm_fold2 import pmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pmm_ctl_t    in_ctl,
  input  logic [82:0] in_y,
  output logic        out_vld,
  output pmm_out_t    out_res
);

  pmm_ctl_t       ctl_h_r, ctl_i_r, ctl_j_r;
  logic           k60;
  logic [22:0]    t;
  logic [61:0]    m;

  logic [42:0]    ct_r, ct_nxt;
  logic [61:0]    m_r;
  logic [63:0]    d64;
  logic [OPW-1:0] d_r;
  logic           neg_r;
  logic [OPW-1:0] res_r, res_nxt;

  assign k60 = sel_k60(in_ctl.sel);
  assign t   = k60 ? in_y[82:60] : {2'b0, in_y[82:62]};
  assign m   = k60 ? {2'b0, in_y[59:0]} : in_y[61:0];

  assign ct_nxt = 43'(t) * 43'(sel_c(in_ctl.sel));

  assign d64 = {2'b0, m_r} - {21'b0, ct_r};

  assign res_nxt = neg_r ? d_r + sel_p(ctl_i_r.sel) : d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_h_r <= '0;
      ctl_i_r <= '0;
      ctl_j_r <= '0;
    end else begin
      ctl_h_r <= in_ctl;
      ctl_i_r <= ctl_h_r;
      ctl_j_r <= ctl_i_r;
    end
  end

  always_ff @(posedge clk) begin
    ct_r  <= ct_nxt;
    m_r   <= m;
    d_r   <= d64[62:0];
    neg_r <= d64[63];
    res_r <= res_nxt;
  end

  assign out_vld             = ctl_j_r.vld;
  assign out_res.residue     = res_r;
  assign out_res.range_error = ctl_j_r.err;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks pseudo_mersenne_modmul request by request against a bit-accurate
// two-fold reduction written here, over every modulus_select value, with
// directed corner operands, random operands and random gaps on the inputs
// ---------------------------------------------------------------------------
module tb;
  import pmm_pkg::*;

  localparam logic [1:0]     SEL_SPARE    = 2'd3;
  localparam logic [2:0]     MODSEL_ADDR  = {REG_MODSEL, 2'b00};
  localparam logic [OPW-1:0] OPND_LIMIT   = (63'd1 << 62) + 63'd622593;
  localparam logic [OPW-1:0] ALL_ONES     = '1;
  localparam int             STALL_LIMIT  = 2000;

  typedef struct packed {
    pmm_in_t  req;
    pmm_out_t res;
  } modmul_exp_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pmm_in_t     in_req = '0;
  logic        out_strobe;
  pmm_out_t    out_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pmm_in_t     request_q[$];
  modmul_exp_t residue_q[$];
  modmul_exp_t want;
  logic [1:0]  modsel_model;
  int          gap_left;
  logic        burst;
  int          mismatches;
  int          idle_cycles;

  pseudo_mersenne_modmul u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] fold_const(input logic [1:0] sel);
    case (sel)
      SEL_P0:  return 64'd57345;
      SEL_P1:  return 64'd106497;
      default: return 64'd622593;
    endcase
  endfunction

  function automatic int unsigned fold_width(input logic [1:0] sel);
    return (sel == SEL_P0) ? 60 : 62;
  endfunction

  function automatic logic [OPW-1:0] prime_of(input logic [1:0] sel);
    return (63'd1 << fold_width(sel)) + 63'(fold_const(sel));
  endfunction

  // product, biased first fold, second fold, one conditional add of p
  function automatic pmm_out_t modmul_expect(input pmm_in_t req, input logic [1:0] sel);
    logic [OPW-1:0] a, b;
    logic [127:0]   prod, y, hi_c;
    logic [63:0]    mask, t, ct, m, r, p, c;
    int unsigned    k;
    pmm_out_t       res;
    a = req.operand_a;
    b = req.operand_b;
    res.range_error = 1'b0;
    if (a >= OPND_LIMIT) begin
      a = {1'b0, a[61:0]};
      res.range_error = 1'b1;
    end
    if (b >= OPND_LIMIT) begin
      b = {1'b0, b[61:0]};
      res.range_error = 1'b1;
    end
    k = fold_width(sel);
    c = fold_const(sel);
    p = 64'(prime_of(sel));
    mask = (64'd1 << k) - 64'd1;
    prod = 128'(a) * 128'(b);
    hi_c = (prod >> k) * 128'(c);
    y = (128'(p) << 20) + (prod & 128'(mask)) - hi_c;
    t = 64'(y >> k) & 64'hFF_FFFF_FFFF;
    ct = t * c;
    m = y[63:0] & mask;
    r = (m >= ct) ? m - ct : m + (p - ct);
    res.residue = r[OPW-1:0];
    return res;
  endfunction

  function automatic logic [OPW-1:0] draw_operand(input logic [1:0] sel);
    logic [OPW-1:0] rnd;
    logic [OPW-1:0] v;
    rnd = 63'({$urandom, $urandom});
    case ($urandom_range(0, 15))
      0, 1:          v = rnd;
      2, 3, 4, 5, 6: v = {1'b0, rnd[61:0]};
      7:             v = prime_of(sel) + 63'($urandom_range(0, 6)) - 63'd3;
      8:             v = OPND_LIMIT + 63'($urandom_range(0, 6)) - 63'd3;
      9:             v = 63'($urandom_range(0, 1000));
      10:            v = (63'd1 << 62) - 63'($urandom_range(1, 4));
      11:            v = 63'd1 << $urandom_range(0, 62);
      12:            v = (63'd1 << 60) + 63'($urandom_range(0, 6)) - 63'd3;
      13:            v = {1'b1, rnd[61:0]};
      default:       v = rnd >> $urandom_range(0, 62);
    endcase
    return v;
  endfunction

  task automatic queue_request(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
    pmm_in_t req;
    req.operand_a = a;
    req.operand_b = b;
    request_q.push_back(req);
  endtask

  task automatic queue_random(input logic [1:0] sel, input int count);
    @(negedge clk);
    repeat (count) queue_request(draw_operand(sel), draw_operand(sel));
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (request_q.size() != 0 || start || residue_q.size() != 0);
  endtask

  task automatic write_modsel(input logic [1:0] sel);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODSEL_ADDR;
    pwdata  <= {30'($urandom), sel};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] sel, input int count);
    write_modsel(sel);
    queue_random(sel, count);
    wait_drain();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
      burst    <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() != 0) begin
        start    <= 1'b1;
        in_req   <= request_q.pop_front();
        gap_left <= burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) burst <= ~burst;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor, scoreboard and stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      modsel_model = MODSEL_RST;
      idle_cycles  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MODSEL_ADDR)
        modsel_model = pwdata[1:0];
      if (start && !busy) begin
        want.req = in_req;
        want.res = modmul_expect(in_req, modsel_model);
        residue_q.push_back(want);
      end
      if (out_strobe) begin
        if (residue_q.size() == 0) begin
          if (mismatches < 10) $display("result with no request outstanding: %h/%b",
                                        out_res.residue, out_res.range_error);
          mismatches++;
        end else begin
          want = residue_q.pop_front();
          if (out_res.residue !== want.res.residue ||
              out_res.range_error !== want.res.range_error) begin
            if (mismatches < 10)
              $display("a=%h b=%h: residue exp %h got %h, range_error exp %b got %b",
                       want.req.operand_a, want.req.operand_b, want.res.residue,
                       out_res.residue, want.res.range_error, out_res.range_error);
            mismatches++;
          end
        end
      end
      if ((start && !busy) || out_strobe || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // corner operands at the reset modulus
    @(negedge clk);
    queue_request('0, '0);
    queue_request(63'd1, 63'd1);
    queue_request(ALL_ONES, ALL_ONES);
    queue_request(OPND_LIMIT - 63'd1, OPND_LIMIT - 63'd1);
    queue_request(OPND_LIMIT, 63'd1);
    queue_request(63'd1, OPND_LIMIT);
    queue_request(OPND_LIMIT, OPND_LIMIT);
    queue_request(prime_of(SEL_P1) - 63'd1, prime_of(SEL_P1) - 63'd1);
    queue_request(prime_of(SEL_P1), 63'd5);
    queue_request(prime_of(SEL_P1) + 63'd1, prime_of(SEL_P1) + 63'd2);
    queue_request(prime_of(SEL_P0) - 63'd1, prime_of(SEL_P0) - 63'd1);
    queue_request(prime_of(SEL_P0), 63'd3);
    queue_request((63'd1 << 62) - 63'd1, (63'd1 << 62) - 63'd1);
    queue_request(63'd1 << 62, 63'd1 << 62);
    queue_request(63'd1 << 60, 63'd1 << 60);
    queue_request((63'd1 << 60) - 63'd1, (63'd1 << 62) - 63'd1);
    queue_request(ALL_ONES, '0);
    queue_request(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
    queue_request(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    queue_request(prime_of(SEL_P2) - 63'd1, 63'd2);
    queue_request(63'h4000_0000_0000_0000 | 63'd1, ALL_ONES >> 1);
    wait_drain();
    queue_random(MODSEL_RST, 220);
    wait_drain();

    run_phase(SEL_P0, 230);
    run_phase(SEL_P2, 230);
    run_phase(SEL_SPARE, 230);
    run_phase(SEL_P1, 230);
    run_phase(SEL_P0, 230);
    run_phase(SEL_P2, 230);

    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && residue_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
